[hdl/huffman_table_match_decoder_defines.svh]
// ---------------------------------------------------------------------------
// Huffman table-match decoder: assertion macros
// Shared property macros for the decoder's own checks.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_MATCH_DECODER_DEFINES_SVH
`define HUFFMAN_TABLE_MATCH_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htmd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htmd: next-cycle check failed");

`endif

[hdl/htmd_pkg.sv]
// ---------------------------------------------------------------------------
// Huffman table-match decoder package
// Payload types, control bundles and constants shared by the decoder files.
// ---------------------------------------------------------------------------
package htmd_pkg;

   localparam int ALPHABET_SIZE_DEF = 256;
   localparam int MAX_CODE_BITS_DEF = 32;

   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 32;
   localparam int BCNT_W  = 4;

   localparam logic [LEN_W-1:0]  LEN_SAT    = 6'd63;
   localparam logic [BCNT_W-1:0] BYTE_BITS  = 4'd8;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [SYM_W-1:0]    entry_symbol;
      logic [CODE_W-1:0]   entry_code;
      logic [LEN_W-1:0]    entry_length;
      logic [BYTE_W-1:0]   data_byte;
   } req_data_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } rsp_data_type;

   typedef struct packed {
      logic accept_load;
      logic accept_byte;
      logic take_bit;
      logic scan_start;
      logic scan_step;
      logic hit_take;
      logic emit;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic req_is_data;
      logic byte_done;
      logic limit_hit;
      logic len_ok;
      logic hit;
      logic scan_end;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

[hdl/huffman_table_match_decoder.sv]
// ---------------------------------------------------------------------------
// Huffman table-match decoder
// Decodes a Huffman bit stream against a loadable code table.
// ---------------------------------------------------------------------------
// Input words arrive on req_valid/req_stall. A load word (kind 0) writes one
// table entry. A data word (kind 1) carries one byte that is decoded most
// significant bit first. Each bit is followed by a scan of the table at one
// entry per cycle through its single read port, stopping early at the first
// match and skipped when the accumulated length exceeds MAX_CODE_BITS. The
// next word is taken once the byte is finished. Each decoded symbol appears on
// rsp_valid/rsp_stall, the final one of a byte marked with last; a finished
// symbol waits in the output register while the next word is accepted.
// When the receiver stalls, the decoder holds before overwriting the output
// register; it takes no further words while a byte's last symbol waits to be
// emitted. csr_write_data sets the bit limit (zero for no limit); bits after
// the limit are ignored.
// Reset clears the table's valid bits, the accumulator, the bit count, the
// limit and any pending output.
// ---------------------------------------------------------------------------
module huffman_table_match_decoder #(
   parameter int ALPHABET_SIZE = htmd_pkg::ALPHABET_SIZE_DEF,
   parameter int MAX_CODE_BITS = htmd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  htmd_pkg::req_data_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output htmd_pkg::rsp_data_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [htmd_pkg::LIMIT_W-1:0]  csr_write_data
);
   import htmd_pkg::*;

   cmd_type    cmd;
   status_type status;

   htmd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   htmd_datapath #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

[hdl/htmd_datapath.sv]
// ---------------------------------------------------------------------------
// Huffman table-match decoder datapath
// Code table memory with entry valid bits, bit shifter, code accumulator,
// stream bit counter, table scan and the result register.
// ---------------------------------------------------------------------------
`include "huffman_table_match_decoder_defines.svh"

module htmd_datapath #(
   parameter int ALPHABET_SIZE = htmd_pkg::ALPHABET_SIZE_DEF,
   parameter int MAX_CODE_BITS = htmd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  htmd_pkg::req_data_type            req_data,
   input  logic                              csr_write_enable,
   input  logic [htmd_pkg::LIMIT_W-1:0]      csr_write_data,
   output logic                              rsp_valid,
   output htmd_pkg::rsp_data_type            rsp_data,
   input  logic                              rsp_stall,
   input  htmd_pkg::cmd_type                 cmd,
   output htmd_pkg::status_type              status
);
   import htmd_pkg::*;

   localparam int IDX_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ENTRY_W = MAX_CODE_BITS + LEN_W;

   // Table memory: code in the upper bits, length in the lower bits.
   logic [ENTRY_W-1:0]       table_mem [ALPHABET_SIZE];

   logic [ALPHABET_SIZE-1:0] entry_valid_ff, entry_valid_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic [LIMIT_W-1:0]       consumed_ff, consumed_in;
   logic [BYTE_W-1:0]        byte_ff, byte_in;
   logic [BCNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [MAX_CODE_BITS-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]         acc_len_ff, acc_len_in;
   logic [IDX_W-1:0]         scan_addr_ff, scan_addr_in;
   logic                     rd_live_ff, rd_live_in;
   logic [IDX_W-1:0]         rd_sym_ff, rd_sym_in;
   logic [ENTRY_W-1:0]       rd_entry_ff;
   logic                     rd_valid_ff;
   logic                     pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]         pend_sym_ff, pend_sym_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_data_type             rsp_data_ff, rsp_data_in;

   logic                     load_in_range;
   logic [IDX_W-1:0]         load_addr;
   logic [LEN_W-1:0]         next_len;
   logic [MAX_CODE_BITS-1:0] rd_code;
   logic [LEN_W-1:0]         rd_len;

   assign load_in_range = ({1'b0, req_data.entry_symbol} < (SYM_W+1)'(ALPHABET_SIZE));
   assign load_addr     = req_data.entry_symbol[IDX_W-1:0];
   assign next_len      = (acc_len_ff == LEN_SAT) ? LEN_SAT : acc_len_ff + 1'b1;
   assign rd_code       = rd_entry_ff[ENTRY_W-1:LEN_W];
   assign rd_len        = rd_entry_ff[LEN_W-1:0];

   // Table write on a load word, registered read while scanning.
   always_ff @(posedge clock) begin
      if (cmd.accept_load && load_in_range) begin
         table_mem[load_addr] <= {req_data.entry_code[MAX_CODE_BITS-1:0],
                                  req_data.entry_length};
      end
      if (cmd.scan_step) begin
         rd_entry_ff <= table_mem[scan_addr_ff];
         rd_valid_ff <= entry_valid_ff[scan_addr_ff];
      end
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (cmd.accept_load && load_in_range) begin
         entry_valid_in[load_addr] = 1'b1;
      end

      limit_in = csr_write_enable ? csr_write_data : limit_ff;

      consumed_in = consumed_ff;
      if (cmd.take_bit && (consumed_ff != {LIMIT_W{1'b1}})) begin
         consumed_in = consumed_ff + 1'b1;
      end

      byte_in    = byte_ff;
      bit_cnt_in = bit_cnt_ff;
      if (cmd.accept_byte) begin
         byte_in    = req_data.data_byte;
         bit_cnt_in = '0;
      end else if (cmd.take_bit) begin
         byte_in    = {byte_ff[BYTE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end

      acc_in     = acc_ff;
      acc_len_in = acc_len_ff;
      if (cmd.hit_take) begin
         acc_in     = '0;
         acc_len_in = '0;
      end else if (cmd.take_bit) begin
         acc_in     = {acc_ff[MAX_CODE_BITS-2:0], byte_ff[BYTE_W-1]};
         acc_len_in = next_len;
      end

      scan_addr_in = scan_addr_ff;
      rd_live_in   = rd_live_ff;
      rd_sym_in    = rd_sym_ff;
      if (cmd.scan_start || cmd.hit_take) begin
         scan_addr_in = '0;
         rd_live_in   = 1'b0;
      end else if (cmd.scan_step) begin
         scan_addr_in = scan_addr_ff + 1'b1;
         rd_live_in   = 1'b1;
         rd_sym_in    = scan_addr_ff;
      end

      // A newly matched symbol waits in the pending slot until it is known
      // whether another symbol follows from the same byte.
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      if (cmd.hit_take) begin
         pend_valid_in = 1'b1;
         pend_sym_in   = SYM_W'(rd_sym_ff);
      end else if (cmd.emit) begin
         pend_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.symbol = pend_sym_ff;
         rsp_data_in.last   = cmd.emit_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         limit_ff       <= '0;
         consumed_ff    <= '0;
         bit_cnt_ff     <= '0;
         acc_ff         <= '0;
         acc_len_ff     <= '0;
         rd_live_ff     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         limit_ff       <= limit_in;
         consumed_ff    <= consumed_in;
         bit_cnt_ff     <= bit_cnt_in;
         acc_ff         <= acc_in;
         acc_len_ff     <= acc_len_in;
         rd_live_ff     <= rd_live_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      byte_ff      <= byte_in;
      scan_addr_ff <= scan_addr_in;
      rd_sym_ff    <= rd_sym_in;
      pend_sym_ff  <= pend_sym_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // During a scan the accumulated length lies between one and the code
   // width, so an equal length also rules out empty and overlong entries.
   always_comb begin
      status.req_is_data = (req_data.kind == KIND_DATA);
      status.byte_done   = (bit_cnt_ff == BYTE_BITS);
      status.limit_hit   = (limit_ff != '0) && (consumed_ff >= limit_ff);
      status.len_ok      = (next_len <= LEN_W'(MAX_CODE_BITS));
      status.hit         = rd_live_ff && rd_valid_ff && (rd_len == acc_len_ff) &&
                           (rd_code == acc_ff);
      status.scan_end    = rd_live_ff && (rd_sym_ff == IDX_W'(ALPHABET_SIZE - 1));
      status.pend_valid  = pend_valid_ff;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HTMD_ASSERT_IMP(a_emit_room, clock, reset, cmd.emit, status.out_free)
   `HTMD_ASSERT_IMP(a_hit_len, clock, reset, cmd.hit_take, (acc_len_ff != '0) && (acc_len_ff <= LEN_W'(MAX_CODE_BITS)))
   `HTMD_ASSERT_NEXT(a_acc_cleared, clock, reset, cmd.hit_take, (acc_len_ff == '0) && (acc_ff == '0))
   `HTMD_ASSERT_IMP(a_bit_in_window, clock, reset, cmd.take_bit, !status.byte_done && !status.limit_hit)

endmodule

[hdl/htmd_controller.sv]
// ---------------------------------------------------------------------------
// Huffman table-match decoder controller
// Sequences word acceptance, bit shifting, table scans and result output.
// ---------------------------------------------------------------------------
module htmd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  htmd_pkg::status_type status,
   output htmd_pkg::cmd_type    cmd
);
   import htmd_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_BIT   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (status.req_is_data) begin
                  cmd.accept_byte = 1'b1;
                  state_in        = ST_BIT;
               end else begin
                  cmd.accept_load = 1'b1;
               end
            end
         end
         ST_BIT: begin
            // Bits beyond the limit are dropped, so the rest of the byte goes too.
            if (status.byte_done || status.limit_hit) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.take_bit = 1'b1;
               if (status.len_ok) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               if (!status.pend_valid) begin
                  cmd.hit_take = 1'b1;
                  state_in     = ST_BIT;
               end else if (status.out_free) begin
                  cmd.hit_take = 1'b1;
                  cmd.emit     = 1'b1;
                  state_in     = ST_BIT;
               end
            end else if (status.scan_end) begin
               state_in = ST_BIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
